@@ rtl/aea_pkg.sv @@
// Shared types, constants and helper functions for the auto-exposure block.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
`timescale 1ns / 1ps

package aea_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int SUM_SCALE_SHIFT = 10;

  localparam logic [16:0] ONE_Q      = 17'(1 << FRAC_BITS);
  localparam logic [31:0] Q30        = 32'h4000_0000;
  localparam logic [31:0] LOG2E_Q30  = 32'd1549082005;
  localparam logic [31:0] LN2_Q30    = 32'd744261118;
  localparam logic [16:0] NIGHT_W0   = 17'((3 * (1 << FRAC_BITS) + 5) / 10);
  localparam logic [19:0] MAX_EPS    = 20'(((1 << FRAC_BITS) + 500) / 1000);
  localparam logic [42:0] TEN_Q      = 43'(10 * (1 << FRAC_BITS));
  localparam logic [22:0] EXP_MAG_MAX = 23'(64 * (1 << FRAC_BITS));
  localparam logic [40:0] SAT_CAP    = {1'b1, 40'd0};

  // 20 * sum * 2^FRAC / (count * 2^SHIFT) reduces to sum * NUM_SCALE / count.
  localparam int NUM_SCALE = 20 << (FRAC_BITS - SUM_SCALE_SHIFT);

  localparam int DIV_NUM_W = 43;
  localparam int DIV_DEN_W = 25;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [2:0] HORNER_TERMS = 3'd6;

  localparam logic [2:0] CFG_ENABLE      = 3'd0;
  localparam logic [2:0] CFG_LUMA_DAY    = 3'd1;
  localparam logic [2:0] CFG_LUMA_NIGHT  = 3'd2;
  localparam logic [2:0] CFG_MIN_MUL     = 3'd3;
  localparam logic [2:0] CFG_MAX_DAY     = 3'd4;
  localparam logic [2:0] CFG_MAX_NIGHT   = 3'd5;
  localparam logic [2:0] CFG_SPEED       = 3'd6;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_DAY_IW, MUL_NIGHT_WU, MUL_MD_IW, MUL_MN_WU, MUL_SPEED_DT,
    MUL_MAG_LOG2E, MUL_F_LN2, MUL_U_ACC, MUL_T_RECIP, MUL_M_POW, MUL_DIFF_ALPHA
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_SUM_LOAD, WB_TL, WB_HI, WB_SPEED, WB_Y, WB_U, WB_T, WB_HACC,
    WB_V, WB_SMOOTH
  } wb_sel_t;

  typedef enum logic [3:0] {
    LD_NONE, LD_BYPASS, LD_NOAPPLY, LD_PREP, LD_EXP_TGT, LD_EXP_ALPHA,
    LD_TARGET, LD_ALPHA, LD_ALPHA_ONE
  } ld_sel_t;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    mul_sel_t   mul_sel;
    wb_sel_t    wb_sel;
    ld_sel_t    ld_sel;
    logic       emit;
    logic [2:0] k;
  } aea_cmd_t;

  typedef struct packed {
    logic bypass;
    logic apply;
    logic alpha_one;
    logic div_busy;
    logic out_free;
  } aea_status_t;

  // Division by the Horner term index: optional pre-shift, then a reciprocal
  // multiply and a right shift. Exact for any 32-bit dividend.
  function automatic logic [1:0] horner_pre(input logic [2:0] k);
    case (k)
      3'd2:    horner_pre = 2'd1;
      3'd4:    horner_pre = 2'd2;
      3'd6:    horner_pre = 2'd1;
      default: horner_pre = 2'd0;
    endcase
  endfunction

  function automatic logic [31:0] horner_mul(input logic [2:0] k);
    case (k)
      3'd3, 3'd6: horner_mul = 32'hAAAA_AAAB;
      3'd5:       horner_mul = 32'hCCCC_CCCD;
      default:    horner_mul = 32'd1;
    endcase
  endfunction

  function automatic logic [5:0] horner_shift(input logic [2:0] k);
    case (k)
      3'd3, 3'd6: horner_shift = 6'd33;
      3'd5:       horner_shift = 6'd34;
      default:    horner_shift = 6'd0;
    endcase
  endfunction

endpackage

@@ rtl/aea_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on aea_pkg for its widths.
`timescale 1ns / 1ps

module aea_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [aea_pkg::DIV_NUM_W-1:0] num,
  input  logic [aea_pkg::DIV_DEN_W-1:0] den,
  output logic                          busy,
  output logic [aea_pkg::DIV_NUM_W-1:0] quot
);

  logic                          busy_r;
  logic [aea_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [aea_pkg::DIV_DEN_W-1:0] rem_r;
  logic [aea_pkg::DIV_DEN_W-1:0] den_r;
  logic [aea_pkg::DIV_NUM_W-1:0] quo_r;
  logic [aea_pkg::DIV_DEN_W:0]   rem_sh;
  logic                          ge;

  assign rem_sh = {rem_r, quo_r[aea_pkg::DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= aea_pkg::DIV_CNT_W'(aea_pkg::DIV_NUM_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? aea_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_r})
                  : rem_sh[aea_pkg::DIV_DEN_W-1:0];
      quo_r <= {quo_r[aea_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;

endmodule

@@ rtl/aea_ctrl.sv @@
// Sequencer of the auto-exposure block: walks one frame through the shared
// multiplier, the divider and the exponential routine. Depends on aea_pkg.
`timescale 1ns / 1ps

module aea_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  aea_pkg::aea_status_t st,
  output aea_pkg::aea_cmd_t    cmd
);

  typedef enum logic [25:0] {
    S_IDLE   = 26'd1 << 0,
    S_DECIDE = 26'd1 << 1,
    S_BL0    = 26'd1 << 2,
    S_BL1    = 26'd1 << 3,
    S_BL2    = 26'd1 << 4,
    S_BL3    = 26'd1 << 5,
    S_BL4    = 26'd1 << 6,
    S_BL5    = 26'd1 << 7,
    S_DWAIT  = 26'd1 << 8,
    S_ETGT   = 26'd1 << 9,
    S_EX_Y   = 26'd1 << 10,
    S_EX_YW  = 26'd1 << 11,
    S_EX_U   = 26'd1 << 12,
    S_EX_UW  = 26'd1 << 13,
    S_H_MUL  = 26'd1 << 14,
    S_H_T    = 26'd1 << 15,
    S_H_REC  = 26'd1 << 16,
    S_H_ACC  = 26'd1 << 17,
    S_EX_V   = 26'd1 << 18,
    S_EX_VW  = 26'd1 << 19,
    S_EX_RET = 26'd1 << 20,
    S_A_ONE  = 26'd1 << 21,
    S_EALPHA = 26'd1 << 22,
    S_SM_MUL = 26'd1 << 23,
    S_SM_WB  = 26'd1 << 24,
    S_EMIT   = 26'd1 << 25
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    ret_nxt       = ret_r;
    cmd.capture   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.mul_sel   = aea_pkg::MUL_NONE;
    cmd.wb_sel    = aea_pkg::WB_NONE;
    cmd.ld_sel    = aea_pkg::LD_NONE;
    cmd.emit      = 1'b0;
    cmd.k         = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.bypass) begin
          cmd.ld_sel = aea_pkg::LD_BYPASS;
          state_nxt  = S_EMIT;
        end else if (st.apply) begin
          cmd.ld_sel    = aea_pkg::LD_PREP;
          cmd.div_start = 1'b1;
          state_nxt     = S_BL0;
        end else begin
          cmd.ld_sel = aea_pkg::LD_NOAPPLY;
          state_nxt  = S_EMIT;
        end
      end
      // Blends overlap the divider: BL1-BL4 write back the previous product
      // while issuing the next; BL0 only issues and BL5 only writes back.
      S_BL0: begin
        cmd.mul_sel = aea_pkg::MUL_DAY_IW;
        state_nxt   = S_BL1;
      end
      S_BL1: begin
        cmd.wb_sel  = aea_pkg::WB_SUM_LOAD;
        cmd.mul_sel = aea_pkg::MUL_NIGHT_WU;
        state_nxt   = S_BL2;
      end
      S_BL2: begin
        cmd.wb_sel  = aea_pkg::WB_TL;
        cmd.mul_sel = aea_pkg::MUL_MD_IW;
        state_nxt   = S_BL3;
      end
      S_BL3: begin
        cmd.wb_sel  = aea_pkg::WB_SUM_LOAD;
        cmd.mul_sel = aea_pkg::MUL_MN_WU;
        state_nxt   = S_BL4;
      end
      S_BL4: begin
        cmd.wb_sel  = aea_pkg::WB_HI;
        cmd.mul_sel = aea_pkg::MUL_SPEED_DT;
        state_nxt   = S_BL5;
      end
      S_BL5: begin
        cmd.wb_sel = aea_pkg::WB_SPEED;
        state_nxt  = S_DWAIT;
      end
      S_DWAIT: begin
        if (!st.div_busy) begin
          state_nxt = S_ETGT;
        end
      end
      S_ETGT: begin
        cmd.ld_sel = aea_pkg::LD_EXP_TGT;
        ret_nxt    = 1'b0;
        state_nxt  = S_EX_Y;
      end
      S_EX_Y: begin
        cmd.mul_sel = aea_pkg::MUL_MAG_LOG2E;
        state_nxt   = S_EX_YW;
      end
      S_EX_YW: begin
        cmd.wb_sel = aea_pkg::WB_Y;
        state_nxt  = S_EX_U;
      end
      S_EX_U: begin
        cmd.mul_sel = aea_pkg::MUL_F_LN2;
        state_nxt   = S_EX_UW;
      end
      S_EX_UW: begin
        cmd.wb_sel = aea_pkg::WB_U;
        k_nxt      = aea_pkg::HORNER_TERMS;
        state_nxt  = S_H_MUL;
      end
      S_H_MUL: begin
        cmd.mul_sel = aea_pkg::MUL_U_ACC;
        state_nxt   = S_H_T;
      end
      S_H_T: begin
        cmd.wb_sel = aea_pkg::WB_T;
        state_nxt  = S_H_REC;
      end
      S_H_REC: begin
        cmd.mul_sel = aea_pkg::MUL_T_RECIP;
        state_nxt   = S_H_ACC;
      end
      S_H_ACC: begin
        cmd.wb_sel = aea_pkg::WB_HACC;
        k_nxt      = k_r - 3'd1;
        state_nxt  = (k_r == 3'd1) ? S_EX_V : S_H_MUL;
      end
      S_EX_V: begin
        cmd.mul_sel = aea_pkg::MUL_M_POW;
        state_nxt   = S_EX_VW;
      end
      S_EX_VW: begin
        cmd.wb_sel = aea_pkg::WB_V;
        state_nxt  = S_EX_RET;
      end
      S_EX_RET: begin
        if (ret_r) begin
          cmd.ld_sel = aea_pkg::LD_ALPHA;
          state_nxt  = S_SM_MUL;
        end else begin
          cmd.ld_sel = aea_pkg::LD_TARGET;
          state_nxt  = st.alpha_one ? S_A_ONE : S_EALPHA;
        end
      end
      S_A_ONE: begin
        cmd.ld_sel = aea_pkg::LD_ALPHA_ONE;
        state_nxt  = S_SM_MUL;
      end
      S_EALPHA: begin
        cmd.ld_sel = aea_pkg::LD_EXP_ALPHA;
        ret_nxt    = 1'b1;
        state_nxt  = S_EX_Y;
      end
      S_SM_MUL: begin
        cmd.mul_sel = aea_pkg::MUL_DIFF_ALPHA;
        state_nxt   = S_SM_WB;
      end
      S_SM_WB: begin
        cmd.wb_sel = aea_pkg::WB_SMOOTH;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/aea_datapath.sv @@
// Datapath of the auto-exposure block: configuration and frame state, the
// shared 32x32 multiplier, the divider and the output register.
// Depends on aea_pkg and aea_div.
`timescale 1ns / 1ps

module aea_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aea_pkg::aea_cmd_t    cmd,
  output aea_pkg::aea_status_t st,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [20:0]          cfg_wdata,
  input  logic                 frame_present,
  input  logic [31:0]          accum_sum,
  input  logic [24:0]          sample_count,
  input  logic [19:0]          delta_time,
  input  logic signed [17:0]   sun_elevation,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [20:0]          exposure,
  output logic                 updated
);

  localparam int F = aea_pkg::FRAC_BITS;

  // Configuration registers.
  logic        en_r;
  logic [16:0] luma_day_r;
  logic [15:0] luma_night_r;
  logic [18:0] min_mul_r;
  logic [20:0] max_day_r;
  logic [19:0] max_night_r;
  logic [19:0] speed_r;

  // Captured frame.
  logic               present_r;
  logic [31:0]        acc_sum_r;
  logic [24:0]        count_r;
  logic [19:0]        dt_r;
  logic signed [17:0] sun_r;

  // Persistent state.
  logic [20:0] smooth_r;
  logic        pending_r;
  logic [24:0] last_count_r;
  logic        upd_r;

  // Working registers.
  logic [16:0] w_r, iw_r;
  logic [20:0] md_r;
  logic [19:0] mn_r;
  logic [63:0] prod_r;
  logic [39:0] sum_r;
  logic [16:0] tl_r;
  logic [20:0] hi_r;
  logic [23:0] amag_r;
  logic [16:0] e_m_r;
  logic        e_neg_r;
  logic [22:0] e_mag_r;
  logic [6:0]  n_r, sh_r;
  logic [29:0] fg_r, u_r;
  logic [31:0] hacc_r, t_r;
  logic [40:0] e_res_r;
  logic [20:0] target_r;
  logic [16:0] alpha_r;

  logic        out_valid_r;
  logic [20:0] out_expo_r;
  logic        out_upd_r;

  logic [31:0]                   mul_a, mul_b;
  logic [63:0]                   prod_nxt;
  logic                          div_busy;
  logic [aea_pkg::DIV_NUM_W-1:0] div_quot;
  logic [aea_pkg::DIV_NUM_W-1:0] div_num;

  logic signed [22:0] w_raw;
  logic [16:0]        w_clamp;
  logic [19:0]        lo_eps;
  logic [39:0]        blend_sum;
  logic [6:0]         y_n;
  logic [29:0]        y_f;
  logic [42:0]        q_dist;
  logic [22:0]        q_mag;
  logic [18:0]        v;
  logic [40:0]        v_res;
  logic               s_ge;
  logic [20:0]        s_diff;
  logic [21:0]        s_delta, s_new;

  aea_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (last_count_r),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign div_num = aea_pkg::DIV_NUM_W'(acc_sum_r) * aea_pkg::DIV_NUM_W'(aea_pkg::NUM_SCALE);

  // Night weight 0.3 - 5*sun, clamped to [0, 1].
  always_comb begin
    w_raw = $signed({6'd0, aea_pkg::NIGHT_W0})
          - ($signed({{5{sun_r[17]}}, sun_r}) * 23'sd5);
    if (w_raw < 0) begin
      w_clamp = '0;
    end else if (w_raw > $signed({6'd0, aea_pkg::ONE_Q})) begin
      w_clamp = aea_pkg::ONE_Q;
    end else begin
      w_clamp = w_raw[16:0];
    end
  end

  assign lo_eps    = 20'(min_mul_r) + aea_pkg::MAX_EPS;
  assign blend_sum = sum_r + prod_r[39:0];

  // Split of y = mag * log2(e) into integer and Q.30 fraction.
  assign y_n = prod_r[F+36:F+30];
  assign y_f = prod_r[F+29:F];

  assign q_dist = (div_quot >= aea_pkg::TEN_Q) ? div_quot - aea_pkg::TEN_Q
                                              : aea_pkg::TEN_Q - div_quot;
  assign q_mag  = (q_dist > 43'(aea_pkg::EXP_MAG_MAX)) ? aea_pkg::EXP_MAG_MAX
                                                       : q_dist[22:0];

  // Final scale of the exponential: shift by the integer part, saturating.
  assign v = prod_r[48:30];
  always_comb begin
    if (e_neg_r) begin
      v_res = 41'(v) >> sh_r;
    end else if (v == '0) begin
      v_res = '0;
    end else if (n_r >= 7'd40 || 41'(v) > (aea_pkg::SAT_CAP >> n_r)) begin
      v_res = aea_pkg::SAT_CAP;
    end else begin
      v_res = 41'(v) << n_r;
    end
  end

  assign s_ge    = target_r >= smooth_r;
  assign s_diff  = s_ge ? target_r - smooth_r : smooth_r - target_r;
  assign s_delta = prod_r[F+21:F];
  assign s_new   = s_ge ? 22'(smooth_r) + s_delta : 22'(smooth_r) - s_delta;

  always_comb begin
    case (cmd.mul_sel)
      aea_pkg::MUL_DAY_IW:     begin mul_a = 32'(luma_day_r);   mul_b = 32'(iw_r); end
      aea_pkg::MUL_NIGHT_WU:   begin mul_a = 32'(luma_night_r); mul_b = 32'(w_r); end
      aea_pkg::MUL_MD_IW:      begin mul_a = 32'(md_r);         mul_b = 32'(iw_r); end
      aea_pkg::MUL_MN_WU:      begin mul_a = 32'(mn_r);         mul_b = 32'(w_r); end
      aea_pkg::MUL_SPEED_DT:   begin mul_a = 32'(speed_r);      mul_b = 32'(dt_r); end
      aea_pkg::MUL_MAG_LOG2E:  begin mul_a = 32'(e_mag_r);      mul_b = aea_pkg::LOG2E_Q30; end
      aea_pkg::MUL_F_LN2:      begin mul_a = 32'(fg_r);         mul_b = aea_pkg::LN2_Q30; end
      aea_pkg::MUL_U_ACC:      begin mul_a = 32'(u_r);          mul_b = hacc_r; end
      aea_pkg::MUL_T_RECIP:    begin mul_a = t_r; mul_b = aea_pkg::horner_mul(cmd.k); end
      aea_pkg::MUL_M_POW:      begin mul_a = 32'(e_m_r);        mul_b = hacc_r; end
      aea_pkg::MUL_DIFF_ALPHA: begin mul_a = 32'(s_diff);       mul_b = 32'(alpha_r); end
      default:                 begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  assign prod_nxt = 64'(mul_a) * 64'(mul_b);

  // Configuration and control-relevant state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= 1'b1;
      luma_day_r   <= 17'd11796;
      luma_night_r <= 16'd2621;
      min_mul_r    <= 19'd16384;
      max_day_r    <= 21'd262144;
      max_night_r  <= 20'd78643;
      speed_r      <= 20'd98304;
      smooth_r     <= 21'(aea_pkg::ONE_Q);
      pending_r    <= 1'b0;
      last_count_r <= '0;
      upd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          aea_pkg::CFG_ENABLE:     en_r         <= cfg_wdata[0];
          aea_pkg::CFG_LUMA_DAY:   luma_day_r   <= cfg_wdata[16:0];
          aea_pkg::CFG_LUMA_NIGHT: luma_night_r <= cfg_wdata[15:0];
          aea_pkg::CFG_MIN_MUL:    min_mul_r    <= cfg_wdata[18:0];
          aea_pkg::CFG_MAX_DAY:    max_day_r    <= cfg_wdata;
          aea_pkg::CFG_MAX_NIGHT:  max_night_r  <= cfg_wdata[19:0];
          aea_pkg::CFG_SPEED:      speed_r      <= cfg_wdata[19:0];
          default: ;
        endcase
      end
      case (cmd.ld_sel)
        aea_pkg::LD_BYPASS: begin
          smooth_r  <= 21'(aea_pkg::ONE_Q);
          pending_r <= 1'b0;
          upd_r     <= 1'b0;
        end
        aea_pkg::LD_NOAPPLY: begin
          pending_r    <= 1'b1;
          last_count_r <= count_r;
          upd_r        <= 1'b0;
        end
        default: ;
      endcase
      if (cmd.wb_sel == aea_pkg::WB_SMOOTH) begin
        if (s_new < 22'(min_mul_r)) begin
          smooth_r <= 21'(min_mul_r);
        end else if (s_new > 22'(hi_r)) begin
          smooth_r <= hi_r;
        end else begin
          smooth_r <= s_new[20:0];
        end
        pending_r    <= 1'b1;
        last_count_r <= count_r;
        upd_r        <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.capture) begin
      present_r <= frame_present;
      acc_sum_r <= accum_sum;
      count_r   <= sample_count;
      dt_r      <= delta_time;
      sun_r     <= sun_elevation;
    end
    if (cmd.emit) begin
      out_expo_r <= smooth_r;
      out_upd_r  <= upd_r;
    end
    case (cmd.ld_sel)
      aea_pkg::LD_PREP: begin
        w_r  <= w_clamp;
        iw_r <= aea_pkg::ONE_Q - w_clamp;
        md_r <= (max_day_r < 21'(lo_eps)) ? 21'(lo_eps) : max_day_r;
        mn_r <= (max_night_r < lo_eps) ? lo_eps : max_night_r;
      end
      aea_pkg::LD_EXP_TGT: begin
        e_m_r   <= tl_r;
        e_neg_r <= div_quot >= aea_pkg::TEN_Q;
        e_mag_r <= q_mag;
      end
      aea_pkg::LD_EXP_ALPHA: begin
        e_m_r   <= aea_pkg::ONE_Q;
        e_neg_r <= 1'b1;
        e_mag_r <= (amag_r > 24'(aea_pkg::EXP_MAG_MAX)) ? aea_pkg::EXP_MAG_MAX
                                                        : amag_r[22:0];
      end
      aea_pkg::LD_TARGET: begin
        if (e_res_r < 41'(min_mul_r)) begin
          target_r <= 21'(min_mul_r);
        end else if (e_res_r > 41'(hi_r)) begin
          target_r <= hi_r;
        end else begin
          target_r <= e_res_r[20:0];
        end
      end
      aea_pkg::LD_ALPHA:     alpha_r <= 17'(41'(aea_pkg::ONE_Q) - e_res_r);
      aea_pkg::LD_ALPHA_ONE: alpha_r <= aea_pkg::ONE_Q;
      default: ;
    endcase
    case (cmd.wb_sel)
      aea_pkg::WB_SUM_LOAD: sum_r  <= prod_r[39:0];
      aea_pkg::WB_TL:       tl_r   <= blend_sum[F+16:F];
      aea_pkg::WB_HI:       hi_r   <= blend_sum[F+20:F];
      aea_pkg::WB_SPEED:    amag_r <= prod_r[F+23:F];
      aea_pkg::WB_Y: begin
        n_r <= y_n;
        if (!e_neg_r) begin
          fg_r <= y_f;
          sh_r <= y_n;
        end else if (y_f == '0) begin
          fg_r <= '0;
          sh_r <= y_n;
        end else begin
          // Negative exponent: 2^-(n+f) = 2^(1-f) / 2^(n+1).
          fg_r <= 30'(aea_pkg::Q30 - 32'(y_f));
          sh_r <= y_n + 7'd1;
        end
      end
      aea_pkg::WB_U: begin
        u_r    <= prod_r[59:30];
        hacc_r <= aea_pkg::Q30;
      end
      aea_pkg::WB_T:    t_r     <= prod_r[61:30] >> aea_pkg::horner_pre(cmd.k);
      aea_pkg::WB_HACC: hacc_r  <= aea_pkg::Q30 + 32'(prod_r >> aea_pkg::horner_shift(cmd.k));
      aea_pkg::WB_V:    e_res_r <= v_res;
      default: ;
    endcase
  end

  assign st.bypass    = !en_r || !present_r;
  assign st.apply     = pending_r && (last_count_r != '0);
  assign st.alpha_one = (speed_r == '0) || (dt_r == '0);
  assign st.div_busy  = div_busy;
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign exposure  = out_expo_r;
  assign updated   = out_upd_r;

endmodule

@@ rtl/auto_exposure_adaptation.sv @@
// Auto-exposure eye adaptation, top level.
// Joins the sequencer and the datapath. Depends on aea_pkg, aea_ctrl and
// aea_datapath.
//
// One input beat is one video frame; each frame returns exactly one output
// beat with the smoothed exposure (unsigned Q.16) and an updated flag in
// out_tuser. Configuration is a simple write port: cfg_we, cfg_addr and
// cfg_wdata, to be written only while no frame is in flight; the block
// itself does not enforce this. With the block disabled, no frame present
// or no pending measurement of non-zero count, a frame goes straight to its
// output beat. A frame that applies a measurement runs a restoring divide
// overlapped with the blends, then two exponentials (one with zero speed or
// zero delta time) on the shared 32x32 multiplier with six-term Horner loops.
// One frame is in flight at a time; in_tready is high only between frames.
// The output beat sits in a register, so a new frame is accepted while the
// previous result still waits; if the receiver stalls, the next result waits
// in the last step until the register frees.
// Reset restores all configuration defaults, sets the exposure to 1.0 and
// clears the pending measurement.
`timescale 1ns / 1ps

module auto_exposure_adaptation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // accum_sum [31:0], sample_count [56:32], delta_time [76:57],
  // sun_elevation [94:77]
  input  logic [95:0] in_tdata,
  // frame_present [0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // exposure [20:0]
  output logic [23:0] out_tdata,
  // updated [0]
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [20:0] cfg_wdata
);

  aea_pkg::aea_cmd_t    cmd;
  aea_pkg::aea_status_t st;
  logic [20:0]          expo;

  aea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  aea_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .frame_present (in_tuser),
    .accum_sum     (in_tdata[31:0]),
    .sample_count  (in_tdata[56:32]),
    .delta_time    (in_tdata[76:57]),
    .sun_elevation (in_tdata[94:77]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .exposure      (expo),
    .updated       (out_tuser)
  );

  assign out_tdata = {3'd0, expo};

endmodule

@@ rtl/aea_checker.sv @@
// Port-level checks for auto_exposure_adaptation, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module aea_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // A held output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // One frame at a time: input closes right after a beat is taken.
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted during a frame");

  // A result appears only when the frame's last step hands it over.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a frame in flight");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind auto_exposure_adaptation aea_checker u_aea_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
